@@ src/calibrated_midpoint_classifier_assert.svh @@
// assertion macros for the midpoint classifier
`ifndef CALIBRATED_MIDPOINT_CLASSIFIER_ASSERT_SVH
`define CALIBRATED_MIDPOINT_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/cmc_pkg.sv @@
// types, constants and microcode rom of the midpoint classifier
package cmc_pkg;

	localparam int TABLE_SIZE = 32;

	localparam int REQ_W     = 2;
	localparam int IDX_W     = 5;
	localparam int CNT_W     = 27;
	localparam int SUM_W     = CNT_W + 1;
	localparam int CLS_OUT_W = 6;

	localparam int IN_W  = ((REQ_W + IDX_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_W = ((CLS_OUT_W + 1 + 7) / 8) * 8;

	localparam int TBL_AW = $clog2(TABLE_SIZE);
	localparam int MID_AW = $clog2(TABLE_SIZE - 1);
	localparam int STEP_W = $clog2(TABLE_SIZE + 1);
	localparam int CLS_W  = STEP_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_STORE    = 2'd0,
		REQ_REBUILD  = 2'd1,
		REQ_CLASSIFY = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		UOP_WAIT,
		UOP_STORE,
		UOP_REBUILD,
		UOP_CLASSIFY,
		UOP_RESULT
	} uop_t;

	typedef enum logic [1:0] {
		JC_NONE,
		JC_DISPATCH,
		JC_LOOP,
		JC_OUT_FREE
	} jc_t;

	localparam int PC_W = 3;
	typedef logic [PC_W-1:0] upc_t;

	localparam upc_t PC_IDLE     = 3'd0;
	localparam upc_t PC_STORE    = 3'd1;
	localparam upc_t PC_REBUILD  = 3'd2;
	localparam upc_t PC_CLASSIFY = 3'd3;
	localparam upc_t PC_RESULT   = 3'd4;

	typedef struct packed {
		uop_t op;
		jc_t  jc;
		upc_t nxt;
	} uword_t;

	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		case (pc)
			PC_IDLE:     w = '{op: UOP_WAIT,     jc: JC_DISPATCH, nxt: PC_IDLE};
			PC_STORE:    w = '{op: UOP_STORE,    jc: JC_NONE,     nxt: PC_RESULT};
			PC_REBUILD:  w = '{op: UOP_REBUILD,  jc: JC_LOOP,     nxt: PC_RESULT};
			PC_CLASSIFY: w = '{op: UOP_CLASSIFY, jc: JC_LOOP,     nxt: PC_RESULT};
			PC_RESULT:   w = '{op: UOP_RESULT,   jc: JC_OUT_FREE, nxt: PC_IDLE};
			default:     w = '{op: UOP_WAIT,     jc: JC_NONE,     nxt: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ src/calibrated_midpoint_classifier.sv @@
// midpoint classifier: microcoded sequencer over calibration and midpoint tables
//
// one input stream (s_axis) carries requests, one output stream (m_axis) gives
// exactly one result item per request, in order.
// store writes a count into a calibration slot; rebuild recomputes every
// midpoint from neighboring calibration slots; classify walks the midpoints
// and updates the held class number.
// steps from accept to output load:
//   store: store step, then result step; unused code: result step only
//   rebuild: loop over the calibration table, then result step (one calibration read per cycle)
//   classify: loop over the midpoint table, then result step (one midpoint read per cycle)
// the table walks set the rate: each table has a single read port.
// the next item is taken as soon as the result sits in the output register;
// if the receiver stalls with a result already waiting, the sequencer holds
// in its result step and takes no new item until that register frees up.
// reset clears both tables (through valid bits), the held class and both
// handshakes; no clearing pass is needed.
module calibrated_midpoint_classifier
	import cmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // req_type, cal_index, measured_count, zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // class_number, classified, zero pad
);

`include "calibrated_midpoint_classifier_assert.svh"

	upc_t              pc_q;
	upc_t              pc_nxt;
	uword_t            uw;
	logic              in_acc;
	logic              out_free;
	logic              loop_last;

	req_t              req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [STEP_W-1:0] step_q;
	logic [CLS_W-1:0]  held_q;

	logic [CNT_W-1:0]  cal_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] cal_vld_q;
	logic [TBL_AW-1:0] cal_ra;
	logic [CNT_W-1:0]  cal_rd_q;
	logic              cal_rv_q;
	logic [CNT_W-1:0]  cal_eff;

	logic [CNT_W-1:0]  mid_mem [TABLE_SIZE-1];
	logic              mid_vld_q;
	logic              mid_re;
	logic [CNT_W-1:0]  mid_rd_q;
	logic [CNT_W-1:0]  mid_eff;

	logic [CNT_W-1:0]  prev_q;
	logic [SUM_W-1:0]  rb_sum;
	logic              ge0_q;
	logic              in_gap;

	logic              m_vld_q;
	logic [OUT_W-1:0]  m_data_q;

	assign uw            = ucode_rom(pc_q);
	assign s_axis_tready = (uw.op == UOP_WAIT);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_vld_q || m_axis_tready;
	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;

	// rebuild runs one step further than classify: its write index trails its read index by two
	assign loop_last = (uw.op == UOP_REBUILD) ? (step_q == STEP_W'(TABLE_SIZE))
	                                          : (step_q == STEP_W'(TABLE_SIZE - 1));

	always_comb begin
		pc_nxt = pc_q;
		case (uw.jc)
			JC_NONE: begin
				pc_nxt = uw.nxt;
			end
			JC_DISPATCH: begin
				if (in_acc) begin
					case (req_t'(s_axis_tdata[REQ_W-1:0]))
						REQ_STORE:    pc_nxt = PC_STORE;
						REQ_REBUILD:  pc_nxt = PC_REBUILD;
						REQ_CLASSIFY: pc_nxt = PC_CLASSIFY;
						default:      pc_nxt = PC_RESULT;
					endcase
				end
			end
			JC_LOOP: begin
				if (loop_last) begin
					pc_nxt = uw.nxt;
				end
			end
			JC_OUT_FREE: begin
				if (out_free) begin
					pc_nxt = uw.nxt;
				end
			end
			default: begin
				pc_nxt = PC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q   <= req_t'(s_axis_tdata[REQ_W-1:0]);
			idx_q   <= s_axis_tdata[REQ_W +: IDX_W];
			count_q <= s_axis_tdata[REQ_W + IDX_W +: CNT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (in_acc) begin
			step_q <= '0;
		end else if (uw.op == UOP_REBUILD || uw.op == UOP_CLASSIFY) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// calibration table
	assign cal_ra  = TBL_AW'(step_q);
	assign cal_eff = cal_rv_q ? cal_rd_q : '0;

	always_ff @(posedge clk) begin
		if (uw.op == UOP_STORE && int'(idx_q) < TABLE_SIZE) begin
			cal_mem[TBL_AW'(idx_q)] <= count_q;
		end
		cal_rd_q <= cal_mem[cal_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_vld_q <= '0;
			cal_rv_q  <= 1'b0;
		end else begin
			if (uw.op == UOP_STORE && int'(idx_q) < TABLE_SIZE) begin
				cal_vld_q[TBL_AW'(idx_q)] <= 1'b1;
			end
			cal_rv_q <= cal_vld_q[cal_ra];
		end
	end

	// midpoint table, written whole by every rebuild
	assign rb_sum  = SUM_W'(prev_q) + SUM_W'(cal_eff);
	assign mid_re  = (uw.op == UOP_CLASSIFY) && (step_q <= STEP_W'(TABLE_SIZE - 2));
	assign mid_eff = mid_vld_q ? mid_rd_q : '0;

	always_ff @(posedge clk) begin
		if (uw.op == UOP_REBUILD && step_q >= STEP_W'(2)) begin
			mid_mem[MID_AW'(step_q - STEP_W'(2))] <= rb_sum[SUM_W-1:1];
		end
		if (mid_re) begin
			mid_rd_q <= mid_mem[MID_AW'(step_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_vld_q <= 1'b0;
		end else if (uw.op == UOP_REBUILD && step_q >= STEP_W'(2)) begin
			mid_vld_q <= 1'b1;
		end
	end

	// previous entry of the walk: cal[step-2] on rebuild, M[step-2] on classify
	always_ff @(posedge clk) begin
		if (uw.op == UOP_REBUILD) begin
			prev_q <= cal_eff;
		end else if (uw.op == UOP_CLASSIFY) begin
			prev_q <= mid_eff;
		end
		if (uw.op == UOP_CLASSIFY && step_q == STEP_W'(1)) begin
			ge0_q <= (count_q >= mid_eff);
		end
	end

	// count strictly between M[step-2] and M[step-1]
	assign in_gap = (count_q < prev_q) && (count_q > mid_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (uw.op == UOP_CLASSIFY && step_q >= STEP_W'(2)) begin
			if (loop_last && count_q <= mid_eff) begin
				held_q <= CLS_W'(TABLE_SIZE);
			end else if (loop_last && ge0_q) begin
				held_q <= CLS_W'(1);
			end else if (in_gap) begin
				held_q <= CLS_W'(step_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (uw.op == UOP_RESULT && out_free) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == UOP_RESULT && out_free) begin
			m_data_q <= {{(OUT_W - CLS_OUT_W - 1){1'b0}}, (req_q == REQ_CLASSIFY),
			             CLS_OUT_W'(held_q)};
		end
	end

	`CMC_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready,
		pc_q != PC_IDLE, "accepted item did not start a routine")
	`CMC_ASSERT_NOW(a_walk_bound, uw.op == UOP_REBUILD || uw.op == UOP_CLASSIFY,
		step_q <= STEP_W'(TABLE_SIZE), "table walk ran past its end")
	`CMC_ASSERT_NOW(a_class_range, 1'b1,
		held_q <= CLS_W'(TABLE_SIZE), "held class beyond table size")
	`CMC_ASSERT_NEXT(a_result_loaded, uw.op == UOP_RESULT && out_free,
		m_axis_tvalid && pc_q == PC_IDLE, "result step did not load the output")

endmodule
